/* design/lrt_pkg.sv */
// ----------------------------------------------------------------------------
// lrt_pkg: shared types and constants for the LRU recency tracker
// Item structs for both channels, action codes, the capacity reset value and
// the control bundle that the tracker broadcasts to every list cell.
// ----------------------------------------------------------------------------
package lrt_pkg;

  // Action codes carried in the request item.
  localparam logic [1:0] ACT_TOUCH  = 2'd0;
  localparam logic [1:0] ACT_INSERT = 2'd1;
  localparam logic [1:0] ACT_EVICT  = 2'd2;

  // Capacity after reset.
  localparam logic [7:0] CAPACITY_RESET = 8'd100;

  // Request item.
  typedef struct packed {
    logic [1:0] action;
    logic [7:0] key;
  } req_t;

  // Response item.
  typedef struct packed {
    logic       present;
    logic       evicted_valid;
    logic [7:0] evicted_key;
    logic       fault;
    logic [7:0] occupancy;
  } rsp_t;

  // Control broadcast to all cells for one item.
  typedef struct packed {
    logic upd;        // an item is accepted this cycle
    logic shift_hit;  // cells up to and including the hit take their left neighbor
    logic shift_all;  // every cell takes its left neighbor
    logic tail_free;  // the tail is the first empty cell instead of the last full one
  } cell_ctrl_t;

endpackage

/* design/lru_recency_tracker.sv */
// ----------------------------------------------------------------------------
// lru_recency_tracker: least recently used replacement list
// Keeps up to capacity distinct keys (capacity clamped into one to MAX_ENTRIES), most recent first, in a row of cells.
//
//   Channel  Direction  Handshake              Payload
//   req      in         req_valid / req_ready  req_t: action, key
//   rsp      out        rsp_valid / rsp_ready  rsp_t: present, evicted_valid,
//                                               evicted_key, fault, occupancy
//   cap      in         cap_we                 cap_wdata: capacity
//
// One item is accepted per cycle; its response is registered and appears in
// the next cycle. All cells match the key in parallel and shift in the same
// cycle, so the hit and tail select chains across the row set the clock.
// Reset is synchronous: the list is empty and capacity returns to 100.
// A new item is taken whenever the response register is empty or being read.
// ----------------------------------------------------------------------------
module lru_recency_tracker
  import lrt_pkg::*;
#(
  parameter int MAX_ENTRIES = 128,
  parameter int KEY_BITS    = 8
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       req_valid,
  output logic       req_ready,
  input  req_t       req,
  output logic       rsp_valid,
  input  logic       rsp_ready,
  output rsp_t       rsp,
  input  logic       cap_we,
  input  logic [7:0] cap_wdata
);

  localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
  localparam int CMP_W = (CNT_W > 8) ? CNT_W : 8;

  logic [7:0]          capacity;
  logic [CNT_W-1:0]    held_count;
  logic [CNT_W-1:0]    held_count_next;

  logic                acc;
  logic [KEY_BITS-1:0] k;
  logic                is_touch;
  logic                is_insert;
  logic                is_evict;
  logic                hit;
  logic                ev_flag;
  logic                fault_flag;
  logic [KEY_BITS-1:0] ev_key;
  cell_ctrl_t          ctrl;

  logic [CMP_W-1:0]    cap_eff;
  logic [CMP_W-1:0]    cnt_ext;
  logic [CMP_W-1:0]    cnt_dec_ext;

  logic [KEY_BITS-1:0] cell_key   [MAX_ENTRIES];
  logic                cell_valid [MAX_ENTRIES];
  logic [MAX_ENTRIES-1:0] match_vec;
  logic                seen_chain [MAX_ENTRIES+1];
  logic [KEY_BITS-1:0] ev_chain   [MAX_ENTRIES+1];

  // Capacity register.
  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= CAPACITY_RESET;
    end else if (cap_we) begin
      capacity <= cap_wdata;
    end
  end

  // Capacity clamped into one to the cell count.
  always_comb begin
    if (capacity == 8'd0) begin
      cap_eff = CMP_W'(1);
    end else if (CMP_W'(capacity) > CMP_W'(MAX_ENTRIES)) begin
      cap_eff = CMP_W'(MAX_ENTRIES);
    end else begin
      cap_eff = CMP_W'(capacity);
    end
  end

  // Handshake and decode of the request item.
  assign req_ready = ~rsp_valid | rsp_ready;
  assign acc       = req_valid & req_ready;
  assign k         = KEY_BITS'(req.key);
  assign is_touch  = (req.action == ACT_TOUCH);
  assign is_insert = (req.action == ACT_INSERT);
  assign is_evict  = (req.action == ACT_EVICT);
  assign hit       = seen_chain[MAX_ENTRIES];

  assign cnt_ext     = CMP_W'(held_count);
  assign cnt_dec_ext = CMP_W'(held_count) - CMP_W'(1);

  // Control broadcast to the cells.
  always_comb begin
    ctrl.upd       = acc;
    ctrl.shift_hit = (is_touch | is_insert) & hit;
    ctrl.shift_all = is_insert & ~hit;
    ctrl.tail_free = is_insert & ~hit;
  end

  // Eviction decision and the count after the item.
  always_comb begin
    ev_flag         = 1'b0;
    fault_flag      = 1'b0;
    held_count_next = held_count;
    if (is_insert) begin
      if (hit) begin
        ev_flag = (cnt_dec_ext >= cap_eff);
        held_count_next = ev_flag ? held_count - CNT_W'(1) : held_count;
      end else begin
        ev_flag = (cnt_ext >= cap_eff);
        held_count_next = ev_flag ? held_count : held_count + CNT_W'(1);
      end
    end else if (is_evict) begin
      if (held_count == '0) begin
        fault_flag = 1'b1;
      end else begin
        ev_flag = 1'b1;
        held_count_next = held_count - CNT_W'(1);
      end
    end
  end

  // Count register.
  always_ff @(posedge clk) begin
    if (rst) begin
      held_count <= '0;
    end else if (acc) begin
      held_count <= held_count_next;
    end
  end

  // Row of cells, most recent at index zero.
  assign seen_chain[0] = 1'b0;
  assign ev_chain[0]   = '0;

  for (genvar i = 0; i < MAX_ENTRIES; i++) begin : g_cell
    logic [KEY_BITS-1:0] left_key;
    logic                left_valid;
    logic                right_valid;

    if (i == 0) begin : g_head
      assign left_key   = k;
      assign left_valid = 1'b1;
    end else begin : g_body
      assign left_key   = cell_key[i-1];
      assign left_valid = cell_valid[i-1];
    end

    if (i == MAX_ENTRIES - 1) begin : g_last
      assign right_valid = 1'b0;
    end else begin : g_inner
      assign right_valid = cell_valid[i+1];
    end

    lrt_cell #(
      .KEY_BITS (KEY_BITS),
      .CNT_W    (CNT_W),
      .INDEX    (i)
    ) u_cell (
      .clk         (clk),
      .rst         (rst),
      .ctrl        (ctrl),
      .key_in      (k),
      .new_count   (held_count_next),
      .left_key    (left_key),
      .left_valid  (left_valid),
      .right_valid (right_valid),
      .seen_in     (seen_chain[i]),
      .ev_in       (ev_chain[i]),
      .key         (cell_key[i]),
      .valid       (cell_valid[i]),
      .match       (match_vec[i]),
      .seen_out    (seen_chain[i+1]),
      .ev_out      (ev_chain[i+1])
    );
  end

  // A full list shifting everything pushes the last key out past the row.
  assign ev_key = ev_chain[MAX_ENTRIES] |
                  ((ctrl.tail_free & cell_valid[MAX_ENTRIES-1]) ?
                   cell_key[MAX_ENTRIES-1] : '0);

  // Response register.
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (acc) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      rsp.present       <= (is_touch | is_insert) & hit;
      rsp.evicted_valid <= ev_flag;
      rsp.evicted_key   <= ev_flag ? 8'(ev_key) : 8'd0;
      rsp.fault         <= fault_flag;
      rsp.occupancy     <= 8'(held_count_next);
    end
  end

  // Keys in the list are distinct, so at most one cell matches.
  assert property (@(posedge clk) disable iff (rst) $onehot0(match_vec))
    else $error("more than one cell matched the key");

  // The valid flags of the head and tail cells follow the count.
  assert property (@(posedge clk) disable iff (rst)
    (cell_valid[0] == (held_count != '0)) &&
    (cell_valid[MAX_ENTRIES-1] == (held_count == CNT_W'(MAX_ENTRIES))))
    else $error("cell valid flags disagree with the count");

  // The count never exceeds the number of cells.
  assert property (@(posedge clk) disable iff (rst)
    CMP_W'(held_count) <= CMP_W'(MAX_ENTRIES))
    else $error("count beyond the cell row");

  // An accepted item always leaves a response in the register.
  assert property (@(posedge clk) disable iff (rst) acc |=> rsp_valid)
    else $error("accepted item produced no response");

endmodule

/* design/lrt_cell.sv */
// ----------------------------------------------------------------------------
// lrt_cell: one entry of the recency list
// Holds one key and its valid flag, compares against the broadcast key, and
// takes its left neighbor's key when the list shifts toward the tail.
// ----------------------------------------------------------------------------
module lrt_cell
  import lrt_pkg::*;
#(
  parameter int KEY_BITS = 8,
  parameter int CNT_W    = 8,
  parameter int INDEX    = 0
) (
  input  logic                clk,
  input  logic                rst,
  input  cell_ctrl_t          ctrl,
  input  logic [KEY_BITS-1:0] key_in,
  input  logic [CNT_W-1:0]    new_count,
  input  logic [KEY_BITS-1:0] left_key,
  input  logic                left_valid,
  input  logic                right_valid,
  input  logic                seen_in,
  input  logic [KEY_BITS-1:0] ev_in,
  output logic [KEY_BITS-1:0] key,
  output logic                valid,
  output logic                match,
  output logic                seen_out,
  output logic [KEY_BITS-1:0] ev_out
);

  logic                shift;
  logic [KEY_BITS-1:0] key_next;
  logic                tail;

  // Match against the broadcast key and pass the hit-seen flag on.
  assign match    = valid && (key == key_in);
  assign seen_out = seen_in | match;

  // A cell shifts when every cell does, or when the hit is at or behind it.
  assign shift    = ctrl.shift_all | (ctrl.shift_hit & ~seen_in);
  assign key_next = shift ? left_key : key;

  // The tail cell supplies the key that leaves the list.
  assign tail   = ctrl.tail_free ? (left_valid & ~valid) : (valid & ~right_valid);
  assign ev_out = ev_in | (tail ? key_next : '0);

  // Key storage needs no reset; only the valid flag is cleared.
  always_ff @(posedge clk) begin
    if (ctrl.upd) begin
      key <= key_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (ctrl.upd) begin
      valid <= (CNT_W'(INDEX) < new_count);
    end
  end

endmodule
